[hw/rtl/pna_pkg.sv]
`default_nettype none

package pna_pkg;

  localparam int PNA_PORT_BITS = 16;
  localparam int PNA_FLAG_BITS = 8;

  typedef enum logic [2:0] {
    ACT_ADD   = 3'd0,
    ACT_ALLOC = 3'd1,
    ACT_DEL   = 3'd2,
    ACT_FIND  = 3'd3,
    ACT_CLEAR = 3'd4
  } pna_action_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_INVALID   = 3'd1,
    STAT_EXISTS    = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_NO_FREE   = 3'd4
  } pna_status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FLAG,
    ST_WIPE,
    ST_RESP
  } pna_state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] port;
    logic [15:0] range_end;
    logic [7:0]  flag_in;
  } pna_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] port_out;
    logic [7:0]  flag_out;
  } pna_out_t;

endpackage

`default_nettype wire

[hw/rtl/pna_ram.sv]
`default_nettype none

module pna_ram #(
  parameter int ADDR_BITS = 11,
  parameter int DATA_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic [ADDR_BITS-1:0] addr_i,
  input  wire logic                 re_i,
  input  wire logic                 we_i,
  input  wire logic [DATA_BITS-1:0] wdata_i,
  output logic      [DATA_BITS-1:0] rdata_o
);

  localparam int Depth = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [Depth];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/pna_ctrl.sv]
`default_nettype none

module pna_ctrl import pna_pkg::*; #(
  parameter int PORT_BITS = PNA_PORT_BITS,
  parameter int FLAG_BITS = PNA_FLAG_BITS,
  parameter int WORD_OFF  = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire pna_in_t                       in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output pna_out_t                           out_item_o,
  output logic [PORT_BITS-WORD_OFF-1:0]      map_addr_o,
  output logic                               map_re_o,
  output logic                               map_we_o,
  output logic [(1<<WORD_OFF)-1:0]           map_wdata_o,
  input  wire logic [(1<<WORD_OFF)-1:0]      map_rdata_i,
  output logic [PORT_BITS-1:0]               flag_addr_o,
  output logic                               flag_re_o,
  output logic                               flag_we_o,
  output logic [FLAG_BITS-1:0]               flag_wdata_o,
  input  wire logic [FLAG_BITS-1:0]          flag_rdata_i
);

  localparam int IdxBits = PORT_BITS - WORD_OFF;
  localparam int WordW   = 1 << WORD_OFF;

  pna_state_e state_q, state_d;
  logic [IdxBits-1:0] clr_q, clr_d;
  logic out_valid_q, out_valid_d;

  logic [2:0]           act_q, act_d;
  logic [PORT_BITS-1:0] port_q, port_d;
  logic [PORT_BITS-1:0] end_q, end_d;
  logic [FLAG_BITS-1:0] flag_q, flag_d;
  logic [IdxBits-1:0]   widx_q, widx_d;
  pna_status_e          res_status_q, res_status_d;
  logic [PORT_BITS-1:0] res_port_q, res_port_d;
  logic [FLAG_BITS-1:0] res_flag_q, res_flag_d;
  pna_out_t             out_item_q, out_item_d;

  logic [PORT_BITS-1:0]   in_port, in_end;
  logic [IdxBits-1:0]     in_idx;
  logic [FLAG_BITS+7:0]   in_flag_ext;
  logic [FLAG_BITS+7:0]   res_flag_ext;
  logic [IdxBits-1:0]     port_idx, end_idx;
  logic [WORD_OFF-1:0]    port_off, end_off;
  logic [WordW-1:0]       port_bit;
  logic                   cur_used;
  logic [WordW-1:0]       cand;
  logic                   hit;
  logic [WORD_OFF-1:0]    hit_off;

  assign in_port     = in_item_i.port[PORT_BITS-1:0];
  assign in_end      = in_item_i.range_end[PORT_BITS-1:0];
  assign in_idx      = in_port[PORT_BITS-1 -: IdxBits];
  assign in_flag_ext = {{FLAG_BITS{1'b0}}, in_item_i.flag_in};
  assign res_flag_ext = {8'b0, res_flag_q};

  assign port_idx = port_q[PORT_BITS-1 -: IdxBits];
  assign port_off = port_q[WORD_OFF-1:0];
  assign end_idx  = end_q[PORT_BITS-1 -: IdxBits];
  assign end_off  = end_q[WORD_OFF-1:0];
  assign port_bit = WordW'(1) << port_off;
  assign cur_used = map_rdata_i[port_off];

  // free bits of the current word that lie inside the range
  always_comb begin
    for (int b = 0; b < WordW; b++) begin
      cand[b] = !map_rdata_i[b]
                && ((widx_q != port_idx) || (WORD_OFF'(b) >= port_off))
                && ((widx_q != end_idx)  || (WORD_OFF'(b) <= end_off));
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_off = '0;
    for (int b = WordW - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit     = 1'b1;
        hit_off = WORD_OFF'(b);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    out_valid_d  = out_valid_q;
    act_d        = act_q;
    port_d       = port_q;
    end_d        = end_q;
    flag_d       = flag_q;
    widx_d       = widx_q;
    res_status_d = res_status_q;
    res_port_d   = res_port_q;
    res_flag_d   = res_flag_q;
    out_item_d   = out_item_q;

    map_addr_o   = widx_q;
    map_re_o     = 1'b0;
    map_we_o     = 1'b0;
    map_wdata_o  = map_rdata_i;
    flag_addr_o  = port_q;
    flag_re_o    = 1'b0;
    flag_we_o    = 1'b0;
    flag_wdata_o = flag_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_INIT, ST_WIPE: begin
        map_addr_o  = clr_q;
        map_we_o    = 1'b1;
        map_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == {IdxBits{1'b1}}) begin
          if (state_q == ST_WIPE) begin
            res_status_d = STAT_OK;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        map_addr_o = in_idx;
        if (in_valid_i) begin
          map_re_o   = 1'b1;
          act_d      = in_item_i.action;
          port_d     = in_port;
          end_d      = in_end;
          flag_d     = in_flag_ext[FLAG_BITS-1:0];
          widx_d     = in_idx;
          res_port_d = in_port;
          res_flag_d = '0;
          case (in_item_i.action) inside
            ACT_ADD, ACT_DEL, ACT_FIND: begin
              state_d = ST_CHECK;
            end
            ACT_ALLOC: begin
              if (in_port > in_end) begin
                res_status_d = STAT_INVALID;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_SCAN;
              end
            end
            ACT_CLEAR: begin
              state_d = ST_WIPE;
            end
            default: begin
              res_status_d = STAT_INVALID;
              state_d      = ST_RESP;
            end
          endcase
        end
      end
      ST_CHECK: begin
        state_d = ST_RESP;
        case (act_q)
          ACT_ADD: begin
            if (cur_used) begin
              res_status_d = STAT_EXISTS;
            end else begin
              map_we_o     = 1'b1;
              map_wdata_o  = map_rdata_i | port_bit;
              flag_we_o    = 1'b1;
              res_status_d = STAT_OK;
            end
          end
          ACT_DEL: begin
            if (cur_used) begin
              map_we_o     = 1'b1;
              map_wdata_o  = map_rdata_i & ~port_bit;
              res_status_d = STAT_OK;
            end else begin
              res_status_d = STAT_NOT_FOUND;
            end
          end
          ACT_FIND: begin
            if (cur_used) begin
              flag_re_o = 1'b1;
              state_d   = ST_FLAG;
            end else begin
              res_status_d = STAT_NOT_FOUND;
            end
          end
          default: begin
            res_status_d = STAT_INVALID;
          end
        endcase
      end
      ST_FLAG: begin
        res_flag_d   = flag_rdata_i;
        res_status_d = STAT_OK;
        state_d      = ST_RESP;
      end
      ST_SCAN: begin
        if (hit) begin
          map_we_o     = 1'b1;
          map_wdata_o  = map_rdata_i | (WordW'(1) << hit_off);
          flag_addr_o  = {widx_q, hit_off};
          flag_we_o    = 1'b1;
          res_port_d   = {widx_q, hit_off};
          res_status_d = STAT_OK;
          state_d      = ST_RESP;
        end else if (widx_q == end_idx) begin
          res_status_d = STAT_NO_FREE;
          state_d      = ST_RESP;
        end else begin
          // fetch the next word while this one is checked
          widx_d     = widx_q + 1'b1;
          map_addr_o = widx_q + 1'b1;
          map_re_o   = 1'b1;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_item_d.status   = res_status_q;
          out_item_d.port_out = 16'(res_port_q);
          out_item_d.flag_out = res_flag_ext[7:0];
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    port_q       <= port_d;
    end_q        <= end_d;
    flag_q       <= flag_d;
    widx_q       <= widx_d;
    res_status_q <= res_status_d;
    res_port_q   <= res_port_d;
    res_flag_q   <= res_flag_d;
    out_item_q   <= out_item_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

[hw/rtl/port_number_allocator_unit.sv]
`default_nettype none

// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o | in_item_i  (pna_in_t)
// out     | output    | out_valid_o/out_stall_i | out_item_o (pna_out_t)
//
// one request at a time; add, delete, find pass ST_CHECK (a find hit also ST_FLAG)
// allocate scans the range one 32-port bitmap word per cycle,
// up to 2^(PORT_BITS-5) words, a rate set by the single read port of the bitmap memory
// clear sweeps the bitmap, one word per cycle, over all 2^(PORT_BITS-5) words
// after reset the same sweep runs (2048 words at 16 port bits) with in_stall_o high
// a result waits in the output register while the next request is taken

module port_number_allocator_unit import pna_pkg::*; #(
  parameter int PORT_BITS = PNA_PORT_BITS,
  parameter int FLAG_BITS = PNA_FLAG_BITS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire pna_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pna_out_t      out_item_o
);

  localparam int WordOff = (PORT_BITS > 5) ? 5 : PORT_BITS - 1;
  localparam int IdxBits = PORT_BITS - WordOff;
  localparam int WordW   = 1 << WordOff;

  logic [IdxBits-1:0]   map_addr;
  logic                 map_re, map_we;
  logic [WordW-1:0]     map_wdata, map_rdata;
  logic [PORT_BITS-1:0] flag_addr;
  logic                 flag_re, flag_we;
  logic [FLAG_BITS-1:0] flag_wdata, flag_rdata;

  pna_ctrl #(
    .PORT_BITS (PORT_BITS),
    .FLAG_BITS (FLAG_BITS),
    .WORD_OFF  (WordOff)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o),
    .map_addr_o   (map_addr),
    .map_re_o     (map_re),
    .map_we_o     (map_we),
    .map_wdata_o  (map_wdata),
    .map_rdata_i  (map_rdata),
    .flag_addr_o  (flag_addr),
    .flag_re_o    (flag_re),
    .flag_we_o    (flag_we),
    .flag_wdata_o (flag_wdata),
    .flag_rdata_i (flag_rdata)
  );

  // in-use bitmap, 32 ports per word
  pna_ram #(
    .ADDR_BITS (IdxBits),
    .DATA_BITS (WordW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .addr_i  (map_addr),
    .re_i    (map_re),
    .we_i    (map_we),
    .wdata_i (map_wdata),
    .rdata_o (map_rdata)
  );

  pna_ram #(
    .ADDR_BITS (PORT_BITS),
    .DATA_BITS (FLAG_BITS)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .addr_i  (flag_addr),
    .re_i    (flag_re),
    .we_i    (flag_we),
    .wdata_i (flag_wdata),
    .rdata_o (flag_rdata)
  );

endmodule

`default_nettype wire

[hw/rtl/pna_checker.sv]
`default_nettype none

module pna_checker import pna_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire pna_in_t  in_item_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire pna_out_t out_item_o
);

  logic       in_xfer, out_xfer;
  logic [1:0] pending_q;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // requests taken whose result has not been transferred yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result without a pending request");

  a_bounded_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> pending_q < 2'd2)
    else $error("request taken while one is in work and one waits");

  a_flag_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != STAT_OK |-> out_item_o.flag_out == 8'd0)
    else $error("flag reported on a failed request");

endmodule

bind port_number_allocator_unit pna_checker u_pna_checker (.*);

`default_nettype wire
